### rtl/core/tpa_pkg.sv
package tpa_pkg;

    localparam int LIGHTS_DEFAULT = 4;
    localparam int NUM_WEIGHTS    = 4;

    localparam int WEIGHT_W = 7;
    localparam int GRANT_W  = 2;
    localparam int CTR_W    = 5;
    localparam int MISS_W   = 8;
    localparam int COUNT_W  = 4;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [CTR_W-1:0] CTR_MAX  = 5'sd15;
    localparam logic [MISS_W-1:0]       MISS_MAX = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_REPORTS_PER_DECISION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_LIMIT            = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_PENALTY         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YIELD_PENALTY        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MISS_THRESHOLD       = 3'd4;

    typedef struct packed {
        logic [3:0] reports_per_decision;
        logic [2:0] win_limit;
        logic [3:0] lock_penalty;
        logic [3:0] yield_penalty;
        logic [7:0] miss_threshold;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        reports_per_decision: 4'd4,
        win_limit:            3'd2,
        lock_penalty:         4'd5,
        yield_penalty:        4'd2,
        miss_threshold:       8'd6
    };

    typedef struct packed {
        logic [GRANT_W-1:0]  granted_light;
        logic [WEIGHT_W-1:0] winning_weight;
        logic [3:0]          lock_mask;
        logic                yield_forced;
    } result_t;

endpackage

### rtl/core/traffic_phase_arbiter_core.sv
// A request accepted into the input register is evaluated there. If it closes a decision,
// its result is registered in the result register and shown on the output from there.
// Throughput: one request per cycle. The single evaluation stage between the input register
// and the result register sets this. It stalls only while a finished decision waits behind an
// untaken result. Reset (rst_n low, asynchronous): configuration, counters and valid flags take
// their defaults at once. The weight and result data registers are not reset.
module traffic_phase_arbiter_core #(
    parameter int LIGHTS = tpa_pkg::LIGHTS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [tpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tpa_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [tpa_pkg::WEIGHT_W-1:0]      weight_0,
    input  logic [tpa_pkg::WEIGHT_W-1:0]      weight_1,
    input  logic [tpa_pkg::WEIGHT_W-1:0]      weight_2,
    input  logic [tpa_pkg::WEIGHT_W-1:0]      weight_3,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tpa_pkg::GRANT_W-1:0]       granted_light,
    output logic [tpa_pkg::WEIGHT_W-1:0]      winning_weight,
    output logic [3:0]                        lock_mask,
    output logic                              yield_forced
);

    tpa_pkg::cfg_t cfg_reg;

    logic [tpa_pkg::NUM_WEIGHTS-1:0][tpa_pkg::WEIGHT_W-1:0] weight_reg;
    logic                                 in_vld_reg;
    logic [tpa_pkg::COUNT_W-1:0]          report_count_reg;
    logic [tpa_pkg::COUNT_W-1:0]          report_count_next;
    logic signed [tpa_pkg::CTR_W-1:0]     win_counter_reg [LIGHTS];
    logic [tpa_pkg::MISS_W-1:0]           missed_rounds_reg [LIGHTS];
    logic signed [tpa_pkg::CTR_W-1:0]     win_counter_next [LIGHTS];
    logic [tpa_pkg::MISS_W-1:0]           missed_rounds_next [LIGHTS];
    tpa_pkg::result_t                     result_next;
    tpa_pkg::result_t                     result_reg;
    logic                                 out_vld_reg;
    logic                                 decide;
    logic                                 proc;

    assign report_count_next = report_count_reg + 4'd1;
    assign decide = (report_count_next == cfg_reg.reports_per_decision);
    assign proc   = in_vld_reg && (!decide || !out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || proc;

    tpa_decide #(
        .LIGHTS(LIGHTS)
    ) u_decide (
        .cfg      (cfg_reg),
        .weight   (weight_reg),
        .ctr_cur  (win_counter_reg),
        .miss_cur (missed_rounds_reg),
        .ctr_new  (win_counter_next),
        .miss_new (missed_rounds_next),
        .result   (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= tpa_pkg::CFG_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tpa_pkg::REG_REPORTS_PER_DECISION:
                    cfg_reg.reports_per_decision <= cfg_data[3:0];
                tpa_pkg::REG_WIN_LIMIT:
                    cfg_reg.win_limit <= cfg_data[2:0];
                tpa_pkg::REG_LOCK_PENALTY:
                    cfg_reg.lock_penalty <= cfg_data[3:0];
                tpa_pkg::REG_YIELD_PENALTY:
                    cfg_reg.yield_penalty <= cfg_data[3:0];
                tpa_pkg::REG_MISS_THRESHOLD:
                    cfg_reg.miss_threshold <= cfg_data;
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            weight_reg <= {weight_3, weight_2, weight_1, weight_0};
        end
        if (proc && decide)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg       <= 1'b0;
            out_vld_reg      <= 1'b0;
            report_count_reg <= '0;
            for (int i = 0; i < LIGHTS; i++)
            begin
                win_counter_reg[i]   <= '0;
                missed_rounds_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (proc && decide)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (proc)
            begin
                if (decide)
                begin
                    report_count_reg <= '0;
                    for (int i = 0; i < LIGHTS; i++)
                    begin
                        win_counter_reg[i]   <= win_counter_next[i];
                        missed_rounds_reg[i] <= missed_rounds_next[i];
                    end
                end
                else
                begin
                    report_count_reg <= report_count_next;
                end
            end
        end
    end

    assign out_valid      = out_vld_reg;
    assign granted_light  = result_reg.granted_light;
    assign winning_weight = result_reg.winning_weight;
    assign lock_mask      = result_reg.lock_mask;
    assign yield_forced   = result_reg.yield_forced;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !in_ready) |-> (out_vld_reg && !out_ready && decide))
    else $error("Input stage stalled without a waiting result.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (proc && !decide) |=> (report_count_reg == $past(report_count_next)))
    else $error("Report count did not advance on a non-deciding request.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !(proc && decide)) |=> !out_valid)
    else $error("Result was repeated after it was taken.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (proc && decide) |=> (out_valid && report_count_reg == '0))
    else $error("Decision did not produce a result and restart the count.");
`endif

endmodule

### rtl/core/tpa_decide.sv
module tpa_decide #(
    parameter int LIGHTS = tpa_pkg::LIGHTS_DEFAULT
) (
    input  tpa_pkg::cfg_t                           cfg,
    input  logic [tpa_pkg::NUM_WEIGHTS-1:0][tpa_pkg::WEIGHT_W-1:0] weight,
    input  logic signed [tpa_pkg::CTR_W-1:0]        ctr_cur [LIGHTS],
    input  logic [tpa_pkg::MISS_W-1:0]              miss_cur [LIGHTS],
    output logic signed [tpa_pkg::CTR_W-1:0]        ctr_new [LIGHTS],
    output logic [tpa_pkg::MISS_W-1:0]              miss_new [LIGHTS],
    output tpa_pkg::result_t                        result
);

    localparam int IDX_W = (LIGHTS > 1) ? $clog2(LIGHTS) : 1;

    logic [tpa_pkg::WEIGHT_W-1:0] best;
    logic [IDX_W-1:0]             chosen;
    logic [tpa_pkg::GRANT_W-1:0]  chosen_grant;
    logic [tpa_pkg::WEIGHT_W-1:0] w;
    logic [3:0]                   lock_bits;
    logic                         yielded;
    logic signed [tpa_pkg::CTR_W-1:0] lim;
    logic signed [tpa_pkg::CTR_W-1:0] lock_val;
    logic signed [tpa_pkg::CTR_W-1:0] yield_val;

    assign lim       = $signed({2'b00, cfg.win_limit});
    assign lock_val  = -$signed({1'b0, cfg.lock_penalty});
    assign yield_val = -$signed({1'b0, cfg.yield_penalty});

    always_comb
    begin
        best         = '0;
        chosen       = '0;
        chosen_grant = '0;
        for (int i = 0; i < LIGHTS; i++)
        begin
            w = '0;
            if (i < tpa_pkg::NUM_WEIGHTS && ctr_cur[i] >= 0)
            begin
                w = weight[i % tpa_pkg::NUM_WEIGHTS];
            end
            if (w > best)
            begin
                best         = w;
                chosen       = IDX_W'(i);
                chosen_grant = tpa_pkg::GRANT_W'(i);
            end
        end
    end

    always_comb
    begin
        lock_bits = '0;
        yielded   = 1'b0;
        for (int i = 0; i < LIGHTS; i++)
        begin
            if (chosen == IDX_W'(i) || ctr_cur[i] < 0)
            begin
                ctr_new[i]  = (ctr_cur[i] < tpa_pkg::CTR_MAX) ? ctr_cur[i] + 5'sd1
                                                              : ctr_cur[i];
                miss_new[i] = '0;
            end
            else
            begin
                ctr_new[i]  = '0;
                miss_new[i] = (miss_cur[i] < tpa_pkg::MISS_MAX) ? miss_cur[i] + 8'd1
                                                                : miss_cur[i];
            end
        end
        // Lights are checked in index order, so a yield can change the
        // counters that later lights are checked against.
        for (int i = 0; i < LIGHTS; i++)
        begin
            if (ctr_new[i] == lim)
            begin
                ctr_new[i] = lock_val;
                if (i < 4)
                begin
                    lock_bits[i % 4] = 1'b1;
                end
            end
            else if (miss_new[i] == cfg.miss_threshold)
            begin
                yielded = 1'b1;
                for (int j = 0; j < LIGHTS; j++)
                begin
                    if (j != i)
                    begin
                        ctr_new[j] = yield_val;
                    end
                end
            end
        end
    end

    assign result.granted_light  = chosen_grant;
    assign result.winning_weight = best;
    assign result.lock_mask      = lock_bits;
    assign result.yield_forced   = yielded;

endmodule
